@@ hw/rtl/alfl_pkg.sv @@
// Shared codes, widths and types for the array linked list with free list.
package alfl_pkg;

  localparam int NODE_CAPACITY_DEF = 64;

  localparam int OPER_W = 3;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  localparam logic [OPER_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OPER_W-1:0] OP_PREPEND = 3'd1;
  localparam logic [OPER_W-1:0] OP_INSERT  = 3'd2;
  localparam logic [OPER_W-1:0] OP_REMOVE  = 3'd3;
  localparam logic [OPER_W-1:0] OP_READ    = 3'd4;
  localparam logic [OPER_W-1:0] OP_WRITE   = 3'd5;
  localparam logic [OPER_W-1:0] OP_SEARCH  = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_POS,
    S_POSD,
    S_TAKE,
    S_LINK,
    S_WISSUE,
    S_WEVAL,
    S_UNLINK,
    S_FREE,
    S_DONE
  } state_t;

  // write strobes into the node store
  typedef struct packed {
    logic next_we;
    logic val_we;
    logic use_we;
    logic use_data;
  } store_we_t;

  // results of the walk comparator
  typedef struct packed {
    logic next_nil;
    logic next_hit;
    logic cur_nil;
    logic val_hit;
  } walk_flags_t;

endpackage

@@ hw/rtl/array_linked_list_with_free_list_core.sv @@
// Top level: request sequencer, list registers and result register of the linked list.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------------
//  request | req_valid | req_stall | operation, position, value
//  result  | rsp_valid | rsp_stall | status, old_value, node_index, node_index_valid,
//          |           |           | list_count, list_empty
//
// Read, write and rejected requests finish without a walk; prepend and insert take
// a free node, insert also relinks the node at position. Append, remove and search
// walk one node per cycle through the single read port of the node store.
// req_stall drops in the same cycle as the result loads, so a new request is
// accepted only once the previous one has finished.
// After reset a clearing pass over every node rebuilds the free chain and
// clears the in-use bits; req_stall stays high meanwhile.
// A finished result holds in the sequencer while the result register waits on rsp_stall.
module array_linked_list_with_free_list_core #(
  parameter int NODE_CAPACITY = alfl_pkg::NODE_CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [alfl_pkg::OPER_W-1:0]         operation,
  input  logic [alfl_pkg::POS_W-1:0]          position,
  input  logic signed [alfl_pkg::VAL_W-1:0]   value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [alfl_pkg::STAT_W-1:0]         status,
  output logic signed [alfl_pkg::VAL_W-1:0]   old_value,
  output logic [alfl_pkg::IDX_W-1:0]          node_index,
  output logic                                node_index_valid,
  output logic [alfl_pkg::CNT_W-1:0]          list_count,
  output logic                                list_empty
);
  import alfl_pkg::*;

  localparam int AW = $clog2(NODE_CAPACITY);      // node address
  localparam int PW = $clog2(NODE_CAPACITY + 1);  // node pointer, null included
  localparam int CW = (PW > POS_W) ? PW : POS_W;  // position compare width
  localparam int OW = (PW > CNT_W) ? PW : CNT_W;  // count output width
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;  // index output width

  localparam logic [PW-1:0] NIL       = PW'(NODE_CAPACITY);
  localparam logic [PW-1:0] LAST_STEP = PW'(NODE_CAPACITY - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_CAPACITY - 1);

  state_t state, state_next;

  // request held for the whole operation
  logic [OPER_W-1:0] op, op_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [VAL_W-1:0]  key, key_next;

  // list registers
  logic [PW-1:0] list_head, list_head_next;
  logic [PW-1:0] free_head, free_head_next;
  logic [PW-1:0] count, count_next;

  // walk and scratch registers
  logic [PW-1:0]    cur, cur_next;
  logic [PW-1:0]    steps, steps_next;
  logic [PW-1:0]    new_n, new_n_next;
  logic [PW-1:0]    p_next, p_next_next;
  logic [VAL_W-1:0] p_val, p_val_next;
  logic [AW-1:0]    clr, clr_next;

  // result being built
  logic [STAT_W-1:0] r_status, r_status_next;
  logic [VAL_W-1:0]  r_oldv, r_oldv_next;
  logic [PW-1:0]     r_idx, r_idx_next;
  logic              r_idx_ok, r_idx_ok_next;

  logic rsp_valid_next;

  // node store port
  store_we_t        st_we;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [PW-1:0]    wr_next, rd_next;
  logic [VAL_W-1:0] wr_val, rd_val;
  logic             rd_use;

  // comparator port
  logic [PW-1:0] cmp_target;
  walk_flags_t   flags;

  logic [CW-1:0] pos_w;
  logic [PW-1:0] pos_p;
  logic [AW-1:0] pos_a;
  logic          pos_lt, pos_ok, full;
  logic [OW-1:0] count_w;
  logic [XW-1:0] idx_w;

  assign pos_w   = CW'(pos);
  assign pos_p   = pos_w[PW-1:0];
  assign pos_a   = pos_w[AW-1:0];
  assign pos_lt  = (pos_w < CW'(NODE_CAPACITY));
  assign pos_ok  = pos_lt && rd_use;
  assign full    = (free_head >= NIL);
  assign count_w = OW'(count);
  assign idx_w   = XW'(r_idx);

  assign req_stall  = (state != S_IDLE);
  assign cmp_target = (op == OP_APPEND) ? new_n : pos_p;

  alfl_node_store #(
    .NODE_CAPACITY(NODE_CAPACITY),
    .AW(AW),
    .PW(PW)
  ) u_store (
    .clk     (clk),
    .we      (st_we),
    .wr_addr (wr_addr),
    .wr_next (wr_next),
    .wr_val  (wr_val),
    .rd_addr (rd_addr),
    .rd_next (rd_next),
    .rd_val  (rd_val),
    .rd_use  (rd_use)
  );

  alfl_walk_cmp #(
    .NODE_CAPACITY(NODE_CAPACITY),
    .PW(PW)
  ) u_cmp (
    .cur    (cur),
    .nxt    (rd_next),
    .target (cmp_target),
    .val    (rd_val),
    .key    (key),
    .flags  (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      list_head <= NIL;
      free_head <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      list_head <= list_head_next;
      free_head <= free_head_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    pos      <= pos_next;
    key      <= key_next;
    cur      <= cur_next;
    steps    <= steps_next;
    new_n    <= new_n_next;
    p_next   <= p_next_next;
    p_val    <= p_val_next;
    r_status <= r_status_next;
    r_oldv   <= r_oldv_next;
    r_idx    <= r_idx_next;
    r_idx_ok <= r_idx_ok_next;
    // result word loads when the sequencer finishes and the register is free
    if (state == S_DONE && !(rsp_valid && rsp_stall)) begin
      status           <= r_status;
      old_value        <= r_oldv;
      node_index       <= idx_w[IDX_W-1:0];
      node_index_valid <= r_idx_ok;
      list_count       <= count_w[CNT_W-1:0];
      list_empty       <= (count == '0);
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    pos_next       = pos;
    key_next       = key;
    list_head_next = list_head;
    free_head_next = free_head;
    count_next     = count;
    cur_next       = cur;
    steps_next     = steps;
    new_n_next     = new_n;
    p_next_next    = p_next;
    p_val_next     = p_val;
    clr_next       = clr;
    r_status_next  = r_status;
    r_oldv_next    = r_oldv;
    r_idx_next     = r_idx;
    r_idx_ok_next  = r_idx_ok;
    rsp_valid_next = rsp_valid && rsp_stall;

    st_we   = '0;
    wr_addr = pos_a;
    wr_next = rd_next;
    wr_val  = key;
    rd_addr = cur[AW-1:0];

    unique case (state)
      S_CLEAR: begin
        // rebuild the free chain and clear in-use: node i links to i+1, last links to null
        st_we.next_we  = 1'b1;
        st_we.use_we   = 1'b1;
        st_we.use_data = 1'b0;
        wr_addr        = clr;
        wr_next        = PW'(clr) + PW'(1);
        clr_next       = clr + AW'(1);
        if (clr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          op_next       = operation;
          pos_next      = position;
          key_next      = value;
          r_status_next = ST_OK;
          r_oldv_next   = '0;
          r_idx_next    = '0;
          r_idx_ok_next = 1'b0;
          state_next    = S_POS;
        end
      end

      S_POS: begin
        rd_addr    = pos_a;
        state_next = S_POSD;
      end

      S_POSD: begin
        // node at position is in; fetch the free head's link for a take
        rd_addr     = free_head[AW-1:0];
        p_next_next = rd_next;
        p_val_next  = rd_val;
        state_next  = S_DONE;
        unique case (op)
          OP_APPEND, OP_PREPEND: begin
            if (full) begin
              r_status_next = ST_FULL;
            end else begin
              state_next = S_TAKE;
            end
          end
          OP_INSERT: begin
            if (!pos_ok) begin
              r_status_next = ST_BAD_POS;
            end else if (full) begin
              r_status_next = ST_FULL;
            end else begin
              state_next = S_TAKE;
            end
          end
          OP_REMOVE: begin
            if (!pos_ok) begin
              r_status_next = ST_BAD_POS;
            end else if (list_head == pos_p) begin
              list_head_next = rd_next;
              state_next     = S_FREE;
            end else begin
              cur_next   = list_head;
              steps_next = '0;
              state_next = S_WISSUE;
            end
          end
          OP_READ: begin
            if (!pos_ok) begin
              r_status_next = ST_BAD_POS;
            end else begin
              r_oldv_next = rd_val;
            end
          end
          OP_WRITE: begin
            if (!pos_ok) begin
              r_status_next = ST_BAD_POS;
            end else begin
              r_oldv_next  = rd_val;
              st_we.val_we = 1'b1;
              wr_addr      = pos_a;
              wr_val       = key;
            end
          end
          OP_SEARCH: begin
            r_status_next = ST_NOTFOUND;
            cur_next      = list_head;
            steps_next    = '0;
            state_next    = S_WISSUE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_TAKE: begin
        // pop the free head and fill it
        new_n_next     = free_head;
        free_head_next = rd_next;
        count_next     = count + PW'(1);
        r_idx_next     = free_head;
        r_idx_ok_next  = 1'b1;
        st_we.next_we  = 1'b1;
        st_we.val_we   = 1'b1;
        st_we.use_we   = 1'b1;
        st_we.use_data = 1'b1;
        wr_addr        = free_head[AW-1:0];
        wr_val         = key;
        state_next     = S_DONE;
        priority case (op)
          OP_PREPEND: begin
            wr_next        = list_head;
            list_head_next = free_head;
          end
          OP_INSERT: begin
            wr_next    = p_next;
            cur_next   = pos_p;
            state_next = S_LINK;
          end
          default: begin
            // append
            wr_next = NIL;
            if (list_head >= NIL) begin
              list_head_next = free_head;
            end else begin
              cur_next   = list_head;
              steps_next = '0;
              state_next = S_WISSUE;
            end
          end
        endcase
      end

      S_LINK: begin
        st_we.next_we = 1'b1;
        wr_addr       = cur[AW-1:0];
        wr_next       = new_n;
        state_next    = S_DONE;
      end

      S_WISSUE: begin
        rd_addr    = cur[AW-1:0];
        state_next = S_WEVAL;
      end

      S_WEVAL: begin
        // rd_* hold node cur; the successor is addressed now for the next step
        rd_addr = rd_next[AW-1:0];
        priority case (op)
          OP_REMOVE: begin
            if (steps == NIL || flags.cur_nil || flags.next_hit) begin
              state_next = (!flags.cur_nil && flags.next_hit) ? S_UNLINK : S_FREE;
            end else begin
              cur_next   = rd_next;
              steps_next = steps + PW'(1);
            end
          end
          OP_SEARCH: begin
            if (flags.cur_nil) begin
              state_next = S_DONE;
            end else if (flags.val_hit) begin
              r_status_next = ST_OK;
              r_idx_next    = cur;
              r_idx_ok_next = 1'b1;
              state_next    = S_DONE;
            end else begin
              cur_next   = rd_next;
              steps_next = steps + PW'(1);
              if (steps == LAST_STEP) begin
                state_next = S_DONE;
              end
            end
          end
          default: begin
            // append: stop at the tail, then link the new node behind cur
            if (flags.next_nil || flags.next_hit) begin
              state_next = S_LINK;
            end else begin
              cur_next   = rd_next;
              steps_next = steps + PW'(1);
              if (steps == LAST_STEP) begin
                state_next = S_LINK;
              end
            end
          end
        endcase
      end

      S_UNLINK: begin
        st_we.next_we = 1'b1;
        wr_addr       = cur[AW-1:0];
        wr_next       = p_next;
        state_next    = S_FREE;
      end

      S_FREE: begin
        // push the removed node on the free list
        st_we.next_we  = 1'b1;
        st_we.use_we   = 1'b1;
        st_we.use_data = 1'b0;
        wr_addr        = pos_a;
        wr_next        = free_head;
        free_head_next = pos_p;
        if (count != '0) begin
          count_next = count - PW'(1);
        end
        r_oldv_next = p_val;
        if (p_next < NIL) begin
          r_idx_next    = p_next;
          r_idx_ok_next = 1'b1;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!(rsp_valid && rsp_stall)) begin
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/alfl_node_store.sv @@
// Node store: value, next link and in-use memories with one write and one registered read.
module alfl_node_store #(
  parameter int NODE_CAPACITY = alfl_pkg::NODE_CAPACITY_DEF,
  parameter int AW = $clog2(NODE_CAPACITY),
  parameter int PW = $clog2(NODE_CAPACITY + 1)
) (
  input  logic                       clk,
  input  alfl_pkg::store_we_t        we,
  input  logic [AW-1:0]              wr_addr,
  input  logic [PW-1:0]              wr_next,
  input  logic [alfl_pkg::VAL_W-1:0] wr_val,
  input  logic [AW-1:0]              rd_addr,
  output logic [PW-1:0]              rd_next,
  output logic [alfl_pkg::VAL_W-1:0] rd_val,
  output logic                       rd_use
);
  import alfl_pkg::*;

  logic [PW-1:0]    next_mem [NODE_CAPACITY];
  logic [VAL_W-1:0] val_mem  [NODE_CAPACITY];
  logic             use_mem  [NODE_CAPACITY];

  always_ff @(posedge clk) begin
    if (we.next_we) begin
      next_mem[wr_addr] <= wr_next;
    end
    if (we.val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (we.use_we) begin
      use_mem[wr_addr] <= we.use_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_next <= next_mem[rd_addr];
    rd_val  <= val_mem[rd_addr];
    rd_use  <= use_mem[rd_addr];
  end

endmodule

@@ hw/rtl/alfl_walk_cmp.sv @@
// Walk comparator shared by every list walk: null checks and link/value matches.
module alfl_walk_cmp #(
  parameter int NODE_CAPACITY = alfl_pkg::NODE_CAPACITY_DEF,
  parameter int PW = $clog2(NODE_CAPACITY + 1)
) (
  input  logic [PW-1:0]              cur,
  input  logic [PW-1:0]              nxt,
  input  logic [PW-1:0]              target,
  input  logic [alfl_pkg::VAL_W-1:0] val,
  input  logic [alfl_pkg::VAL_W-1:0] key,
  output alfl_pkg::walk_flags_t      flags
);
  import alfl_pkg::*;

  localparam logic [PW-1:0] NIL = PW'(NODE_CAPACITY);

  assign flags.next_nil = (nxt >= NIL);
  assign flags.next_hit = (nxt == target);
  assign flags.cur_nil  = (cur >= NIL);
  assign flags.val_hit  = (val == key);

endmodule
